>>> hw/rtl/mctg_pkg.sv
// Package for the metronome click track generator.
// Holds field widths, register indexes, reset values and the queue word type.
// No dependencies.
`timescale 1ns / 1ps

package mctg_pkg;

  // field widths
  localparam int unsigned PHASE_W     = 16;
  localparam int unsigned EXP_W       = 20;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned POS24_W     = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // default parameter values
  localparam int unsigned SINE_TABLE_DEPTH_DEF   = 1024;
  localparam int unsigned EXP_TABLE_DEPTH_DEF    = 256;
  localparam int unsigned SAMPLE_INDEX_WIDTH_DEF = 24;

  // decoupling queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [PERIOD_W-1:0] BEAT_PERIOD_RST  = 32'd5644800;
  localparam logic [POS24_W-1:0]  FIRST_BEAT_RST   = 24'd0;
  localparam logic [POS24_W-1:0]  TRACK_LENGTH_RST = 24'd441000;
  localparam logic [OFFSET_W-1:0] CLICK_LENGTH_RST = 16'd4410;
  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST   = 16'd1486;
  localparam logic [EXP_W-1:0]    DECAY_STEP_RST   = 20'd149;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAT_PERIOD  = 3'd0,
    REG_FIRST_BEAT   = 3'd1,
    REG_TRACK_LENGTH = 3'd2,
    REG_CLICK_LENGTH = 3'd3,
    REG_PHASE_STEP   = 3'd4,
    REG_DECAY_STEP   = 3'd5
  } cfg_reg_e;

  // per-sample flags carried down the synthesis pipeline
  typedef struct packed {
    logic active;
    logic beat;
    logic last;
  } flags_t;

  // one word in the queue between the sequencer and the synthesis pipeline
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [EXP_W-1:0]   expo;
    flags_t             flags;
  } item_t;

endpackage

>>> hw/rtl/metronome_click_track_generator.sv
// Metronome click track generator, top level.
// Instantiates mctg_front, mctg_queue and mctg_back; depends on mctg_pkg.
//
// Usage: each word on the input channel (in_valid_i / in_stall_o, field
// restart_i) is one audio tick and yields exactly one output word
// (out_valid_o / out_stall_i, fields sample_o, beat_start_o, last_o).
// A word is taken at a clock edge with valid high and stall low.
// Throughput: one word per cycle on both channels while out_stall_i is low.
// Pipeline: each accepted word is written into the queue; the queue head is
// folded into the first quadrant in one stage, then five stages follow,
// each one multiply deep, the last being the output register.
// The sequencer updates its counters in the accepting cycle, so ticks may
// follow each other on every clock while in_stall_o is low.
// Stall: when out_stall_i holds the output word, the synthesis pipeline
// freezes; the four-entry queue keeps absorbing ticks and in_stall_o rises
// only once it is full.
// Reset: registers take their default values, the track is at sample zero
// with the first beat pending, the queue and pipeline are empty.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// next edge; first_beat is used at reset and restart only.
`timescale 1ns / 1ps

module metronome_click_track_generator
  import mctg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH   = SINE_TABLE_DEPTH_DEF,
  parameter int unsigned EXP_TABLE_DEPTH    = EXP_TABLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_INDEX_WIDTH = SAMPLE_INDEX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       beat_start_o,
  output logic                       last_o
);

  logic  push, pop, full, empty;
  item_t push_data, head;

  assign in_stall_o = full;

  // beat sequencer
  mctg_front #(
    .SampleIndexWidth(SAMPLE_INDEX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .restart_i (restart_i),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_data)
  );

  // decoupling queue
  mctg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  // click synthesizer
  mctg_back #(
    .SineTableDepth(SINE_TABLE_DEPTH),
    .ExpTableDepth (EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .beat_start_o(beat_start_o),
    .last_o      (last_o)
  );

endmodule

>>> hw/rtl/mctg_front.sv
// Beat sequencer: configuration registers, track and click counters.
// Turns each accepted tick into a queue word with phase, exponent and flags.
// Depends on mctg_pkg.
`timescale 1ns / 1ps

module mctg_front
  import mctg_pkg::*;
#(
  parameter int unsigned SampleIndexWidth = SAMPLE_INDEX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  restart_i,
  input  logic                  full_i,
  output logic                  push_o,
  output item_t                 item_o
);

  localparam int unsigned SIW = SampleIndexWidth;
  localparam int unsigned PW  = SIW + 8;
  localparam int unsigned CW  = (SIW > POS24_W) ? SIW : POS24_W;
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned AW  = ((PW > PERIOD_W) ? PW : PERIOD_W) + 1;

  // configuration registers
  logic [PERIOD_W-1:0] beat_period_q;
  logic [POS24_W-1:0]  first_beat_q, track_length_q;
  logic [OFFSET_W-1:0] click_length_q;
  logic [PHASE_W-1:0]  phase_step_q;
  logic [EXP_W-1:0]    decay_step_q;

  // track state
  logic [SIW-1:0]      sample_index_q, sample_index_d;
  logic [PW-1:0]       next_beat_q, next_beat_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic                active_q, active_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [EXP_W-1:0]    expo_q, expo_d;

  // working values
  logic [SIW-1:0]      si;
  logic [PW-1:0]       nbp;
  logic [OFFSET_W-1:0] off;
  logic                act;
  logic [PHASE_W-1:0]  ph;
  logic [EXP_W-1:0]    ex;
  logic                running, beat, last;
  logic [AW-1:0]       nxt;
  logic [CW1-1:0]      si_inc;
  logic [EXP_W:0]      ex_sum;
  logic [OFFSET_W-1:0] off_n;

  assign push_o = in_valid_i && !full_i;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_period_q  <= BEAT_PERIOD_RST;
      first_beat_q   <= FIRST_BEAT_RST;
      track_length_q <= TRACK_LENGTH_RST;
      click_length_q <= CLICK_LENGTH_RST;
      phase_step_q   <= PHASE_STEP_RST;
      decay_step_q   <= DECAY_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BEAT_PERIOD:  beat_period_q  <= cfg_data_i;
        REG_FIRST_BEAT:   first_beat_q   <= cfg_data_i[POS24_W-1:0];
        REG_TRACK_LENGTH: track_length_q <= cfg_data_i[POS24_W-1:0];
        REG_CLICK_LENGTH: click_length_q <= cfg_data_i[OFFSET_W-1:0];
        REG_PHASE_STEP:   phase_step_q   <= cfg_data_i[PHASE_W-1:0];
        REG_DECAY_STEP:   decay_step_q   <= cfg_data_i[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // restart, beat test, click output and advance for one tick
  always_comb begin
    si  = restart_i ? '0 : sample_index_q;
    nbp = restart_i ? PW'({first_beat_q, 8'h00}) : next_beat_q;
    off = restart_i ? '0 : offset_q;
    act = restart_i ? 1'b0 : active_q;
    ph  = restart_i ? '0 : phase_q;
    ex  = restart_i ? '0 : expo_q;

    running = CW'(si) < CW'(track_length_q);
    beat    = running && (nbp[PW-1:8] <= si);
    nxt     = AW'(nbp) + AW'(beat_period_q);

    if (beat) begin
      act = 1'b1;
      off = '0;
      ph  = '0;
      ex  = '0;
      nbp = (|nxt[AW-1:PW]) ? '1 : nxt[PW-1:0];
    end

    item_o.phase        = ph;
    item_o.expo         = ex;
    item_o.flags.active = running && act;
    item_o.flags.beat   = beat;

    si_inc = CW1'(si) + CW1'(1);
    last   = running && (si_inc == CW1'(track_length_q));
    item_o.flags.last = last;

    off_n  = off + OFFSET_W'(1);
    ex_sum = (EXP_W + 1)'(ex) + (EXP_W + 1)'(decay_step_q);

    sample_index_d = si;
    next_beat_d    = nbp;
    offset_d       = off;
    active_d       = act;
    phase_d        = ph;
    expo_d         = ex;
    if (running) begin
      sample_index_d = si + SIW'(1);
      if (act) begin
        offset_d = off_n;
        phase_d  = ph + phase_step_q;
        expo_d   = ex_sum[EXP_W] ? '1 : ex_sum[EXP_W-1:0];
        active_d = !((off_n == '0) || (off_n >= click_length_q));
      end
    end
  end

  // state update on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      next_beat_q    <= PW'({FIRST_BEAT_RST, 8'h00});
      offset_q       <= '0;
      active_q       <= 1'b0;
      phase_q        <= '0;
      expo_q         <= '0;
    end else if (push_o) begin
      sample_index_q <= sample_index_d;
      next_beat_q    <= next_beat_d;
      offset_q       <= offset_d;
      active_q       <= active_d;
      phase_q        <= phase_d;
      expo_q         <= expo_d;
    end
  end

endmodule

>>> hw/rtl/mctg_queue.sv
// Small queue of sequencer words between the beat sequencer and the synthesizer.
// Depends on mctg_pkg.
`timescale 1ns / 1ps

module mctg_queue
  import mctg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // fill count
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/mctg_back.sv
// Click synthesizer: polynomial sine and exponential envelope, at most one multiply deep
// per stage, ending in the output register. Depends on mctg_pkg.
`timescale 1ns / 1ps

module mctg_back
  import mctg_pkg::*;
#(
  parameter int unsigned SineTableDepth = SINE_TABLE_DEPTH_DEF,
  parameter int unsigned ExpTableDepth  = EXP_TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  item_t                      head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       beat_start_o,
  output logic                       last_o
);

  localparam int unsigned SB = $clog2(SineTableDepth);
  localparam int unsigned EB = $clog2(ExpTableDepth);
  localparam logic [PHASE_W-1:0] SINE_MASK =
      PHASE_W'(~((32'd1 << (PHASE_W - SB)) - 32'd1));
  localparam logic [15:0] EXP_MASK = 16'(~((32'd1 << (16 - EB)) - 32'd1));

  logic adv;

  // stage valids
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q, v_o_q;

  // stage a: quadrant fold and envelope fraction
  logic [PHASE_W-1:0] p_s;
  logic [16:0]        xr_s, x_s;
  logic [16:0]        x_a_q;
  logic               neg_a_q;
  logic [15:0]        u_a_q;
  logic [3:0]         ish_a_q;
  flags_t             fl_a_q;

  // stage b
  logic [33:0] pxx;
  logic [27:0] pu1;
  logic [16:0] x_b_q, x2_b_q;
  logic        neg_b_q;
  logic [15:0] u_b_q;
  logic [3:0]  ish_b_q;
  logic [13:0] g1_b_q;
  flags_t      fl_b_q;

  // stage c
  logic [29:0] p1, p2;
  logic [16:0] x_c_q, x2_c_q;
  logic [15:0] t1_c_q, g2_c_q, u_c_q;
  logic        neg_c_q;
  logic [3:0]  ish_c_q;
  flags_t      fl_c_q;

  // stage d
  logic [32:0] p3;
  logic [31:0] p4;
  logic [16:0] x_d_q, t2_d_q, g3_d_q;
  logic        neg_d_q;
  logic [3:0]  ish_d_q;
  flags_t      fl_d_q;

  // stage e
  logic [33:0] p5;
  logic [16:0] y1;
  logic [14:0] mag_e_q;
  logic [16:0] gain_e_q;
  logic        neg_e_q;
  flags_t      fl_e_q;

  // output stage
  logic [31:0]                p6;
  logic [SAMPLE_W-1:0]        amp;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       beat_q, last_q;

  // whole pipeline moves unless the output word is held
  assign adv   = !v_o_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  assign out_valid_o  = v_o_q;
  assign sample_o     = sample_q;
  assign beat_start_o = beat_q;
  assign last_o       = last_q;

  // phase truncated to the table grid, folded into the first quadrant
  always_comb begin
    p_s  = head_i.phase & SINE_MASK;
    xr_s = {1'b0, p_s[13:0], 2'b00};
    x_s  = p_s[14] ? (17'h10000 - xr_s) : xr_s;
  end

  // products for each stage
  always_comb begin
    pxx = x_a_q * x_a_q;
    pu1 = u_a_q * 12'd2949;
    p1  = x2_b_q * 13'd5223;
    p2  = u_b_q * g1_b_q;
    p3  = x2_c_q * t1_c_q;
    p4  = u_c_q * g2_c_q;
    p5  = x_d_q * t2_d_q;
    y1  = p5[33:17];
    p6  = mag_e_q * gain_e_q;
    amp = {1'b0, p6[30:16]};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_o_q <= 1'b0;
    end else if (adv) begin
      v_a_q <= !empty_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
      v_e_q <= v_d_q;
      v_o_q <= v_e_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage a
      x_a_q   <= x_s;
      neg_a_q <= p_s[15];
      u_a_q   <= head_i.expo[15:0] & EXP_MASK;
      ish_a_q <= head_i.expo[19:16];
      fl_a_q  <= head_i.flags;
      // stage b: x squared, first envelope term
      x_b_q   <= x_a_q;
      x2_b_q  <= pxx[32:16];
      neg_b_q <= neg_a_q;
      u_b_q   <= u_a_q;
      ish_b_q <= ish_a_q;
      g1_b_q  <= 14'd15598 - {2'b00, pu1[27:16]};
      fl_b_q  <= fl_a_q;
      // stage c
      x_c_q   <= x_b_q;
      x2_c_q  <= x2_b_q;
      t1_c_q  <= 16'd42334 - {2'b00, p1[29:16]};
      g2_c_q  <= 16'd45416 - {2'b00, p2[29:16]};
      u_c_q   <= u_b_q;
      neg_c_q <= neg_b_q;
      ish_c_q <= ish_b_q;
      fl_c_q  <= fl_b_q;
      // stage d
      x_d_q   <= x_c_q;
      t2_d_q  <= 17'd102944 - p3[32:16];
      g3_d_q  <= 17'h10000 - {1'b0, p4[31:16]};
      neg_d_q <= neg_c_q;
      ish_d_q <= ish_c_q;
      fl_d_q  <= fl_c_q;
      // stage e: sine magnitude, saturated, and shifted gain
      mag_e_q  <= (y1 > 17'd32767) ? 15'h7fff : y1[14:0];
      gain_e_q <= g3_d_q >> ish_d_q;
      neg_e_q  <= neg_d_q;
      fl_e_q   <= fl_d_q;
      // output word
      if (fl_e_q.active) begin
        sample_q <= neg_e_q ? -amp : amp;
      end else begin
        sample_q <= '0;
      end
      beat_q <= fl_e_q.beat;
      last_q <= fl_e_q.last;
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for metronome_click_track_generator.
// Drives ticks, predicts every audio word with an in-bench model of the click synthesis,
// and compares each output word in order; depends on mctg_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
  import mctg_pkg::*;

  localparam int unsigned RANDOM_TICKS   = 950;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned MAX_PRINTED    = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                beat;
    logic                last;
  } click_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       beat_start;
  logic                       last;

  // ticks waiting to be offered and words waiting to come out
  logic        tick_q[$];
  click_word_t due_words[$];

  // register copies
  logic [31:0] period_cfg;
  logic [23:0] first_cfg;
  logic [23:0] length_cfg;
  logic [15:0] click_len_cfg;
  logic [15:0] step_cfg;
  logic [19:0] decay_cfg;

  // track state
  logic [23:0] idx_now;
  logic [31:0] beat_pos;
  logic [15:0] click_pos;
  logic        click_on;
  logic [15:0] phase_acc;
  logic [19:0] decay_acc;

  int unsigned feed_idle_pct = 38;
  int unsigned drain_idle_pct = 58;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned quiet_cycles = 0;

  metronome_click_track_generator i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .restart_i    (restart),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_o     (sample),
    .beat_start_o (beat_start),
    .last_o       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // append a tick to the pending list
  function automatic void append_tick(input logic r);
    tick_q.insert(tick_q.size(), r);
  endfunction

  // append a predicted word to the expected list
  function automatic void append_word(input click_word_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  // quantized sine, signed q1.15
  function automatic int sine_q15(input logic [15:0] ph);
    logic [63:0] idx, p, x, x2, t, y;
    logic [1:0]  quad;
    idx  = (64'(ph) * SINE_TABLE_DEPTH_DEF) >> 16;
    p    = (idx << 16) / SINE_TABLE_DEPTH_DEF;
    quad = p[15:14];
    x    = (p & 64'h3FFF) << 2;
    if (quad[0]) begin
      x = 64'd65536 - x;
    end
    x2 = (x * x) >> 16;
    t  = 64'd42334 - ((x2 * 64'd5223) >> 16);
    t  = 64'd102944 - ((x2 * t) >> 16);
    y  = ((x * t) >> 16) >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return quad[1] ? -int'(y) : int'(y);
  endfunction

  // envelope gain 2^-e, q16
  function automatic logic [31:0] env_gain(input logic [19:0] e);
    logic [63:0] q, u, g;
    q = (64'(e[15:0]) * EXP_TABLE_DEPTH_DEF) >> 16;
    u = (q << 16) / EXP_TABLE_DEPTH_DEF;
    g = 64'd15598 - ((u * 64'd2949) >> 16);
    g = 64'd45416 - ((u * g) >> 16);
    g = 64'd65536 - ((u * g) >> 16);
    return 32'(g >> e[19:16]);
  endfunction

  task automatic restart_state();
    idx_now   = '0;
    beat_pos  = {first_cfg, 8'h00};
    click_pos = '0;
    click_on  = 1'b0;
    phase_acc = '0;
    decay_acc = '0;
  endtask

  // one tick of the click track: beat test, output, click advance
  task automatic synth_tick(input logic rst_track, output click_word_t w);
    int          sv;
    logic [31:0] mag, amp;
    logic [32:0] pos_sum;
    logic [20:0] ex_sum;
    w = '0;
    if (rst_track) begin
      restart_state();
    end
    if (idx_now < length_cfg) begin
      if (beat_pos[31:8] <= idx_now) begin
        w.beat    = 1'b1;
        click_on  = 1'b1;
        click_pos = '0;
        phase_acc = '0;
        decay_acc = '0;
        pos_sum   = {1'b0, beat_pos} + {1'b0, period_cfg};
        beat_pos  = pos_sum[32] ? '1 : pos_sum[31:0];
      end
      if (click_on) begin
        sv        = sine_q15(phase_acc);
        mag       = (sv < 0) ? 32'(-sv) : 32'(sv);
        amp       = 32'((64'(mag) * 64'(env_gain(decay_acc))) >> 16);
        w.sample  = (sv < 0) ? -amp[15:0] : amp[15:0];
        click_pos = click_pos + 16'd1;
        phase_acc = phase_acc + step_cfg;
        ex_sum    = {1'b0, decay_acc} + {1'b0, decay_cfg};
        decay_acc = ex_sum[20] ? '1 : ex_sum[19:0];
        if (click_pos == 16'd0 || click_pos >= click_len_cfg) begin
          click_on = 1'b0;
        end
      end
      if ({1'b0, idx_now} + 25'd1 == {1'b0, length_cfg}) begin
        w.last = 1'b1;
      end
      idx_now = idx_now + 24'd1;
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch in %s at word %0d: got %0d, expected %0d", field, words_seen, got,
               want);
    end
  endtask

  // sender: offer queued ticks, predict each accepted one
  always @(posedge clk or negedge rst_n) begin
    click_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        synth_tick(restart, w);
        append_word(w);
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= feed_idle_pct) begin
          in_valid <= 1'b1;
          restart  <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check words, stall at random, one long hold-off
  always @(posedge clk or negedge rst_n) begin
    click_word_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word", int'(sample), 0);
        end else begin
          w = due_words.pop_front();
          if (sample !== w.sample) begin
            report_mismatch("sample", int'(sample), int'($signed(w.sample)));
          end
          if (beat_start !== w.beat) begin
            report_mismatch("beat_start", int'(beat_start), int'(w.beat));
          end
          if (last !== w.last) begin
            report_mismatch("last", int'(last), int'(w.last));
          end
        end
        words_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_armed && !hold_done && in_valid && tick_q.size() >= 12) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < drain_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // register write, model copy updated alongside
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_BEAT_PERIOD:  period_cfg    = data;
      REG_FIRST_BEAT:   first_cfg     = data[23:0];
      REG_TRACK_LENGTH: length_cfg    = data[23:0];
      REG_CLICK_LENGTH: click_len_cfg = data[15:0];
      REG_PHASE_STEP:   step_cfg      = data[15:0];
      REG_DECAY_STEP:   decay_cfg     = data[19:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_track(input logic [31:0] per, input logic [23:0] first,
                               input logic [23:0] len, input logic [15:0] clen,
                               input logic [15:0] pstep, input logic [19:0] dstep);
    write_reg(REG_BEAT_PERIOD, per);
    write_reg(REG_FIRST_BEAT, 32'(first));
    write_reg(REG_TRACK_LENGTH, 32'(len));
    write_reg(REG_CLICK_LENGTH, 32'(clen));
    write_reg(REG_PHASE_STEP, 32'(pstep));
    write_reg(REG_DECAY_STEP, 32'(dstep));
  endtask

  // wait until every tick is taken and every word has come out
  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || due_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // queue n ticks, bit i of the pattern is the restart flag of tick i
  task automatic push_ticks(input logic [7:0] pattern, input int n);
    for (int i = 0; i < n; i++) begin
      append_tick(pattern[i]);
    end
    drain();
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        feed_idle_pct  = 38;
        drain_idle_pct = 58;
      end
      1: begin
        feed_idle_pct  = 58;
        drain_idle_pct = 38;
      end
      default: begin
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        hold_armed     = 1'b1;
      end
    endcase
  endtask

  initial begin
    int unsigned rand_ticks;
    int          n;
    logic [31:0] per;
    logic [23:0] first, len;
    logic [15:0] clen, pstep;
    logic [19:0] dstep;

    period_cfg    = BEAT_PERIOD_RST;
    first_cfg     = FIRST_BEAT_RST;
    length_cfg    = TRACK_LENGTH_RST;
    click_len_cfg = CLICK_LENGTH_RST;
    step_cfg      = PHASE_STEP_RST;
    decay_cfg     = DECAY_STEP_RST;
    restart_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // reset defaults: beat at sample zero, then a restart mid-click
    push_ticks(8'b0000_1000, 5);
    // sub-sample period (beat every sample), zero click length, track end
    program_track(32'd0, 24'd0, 24'd3, 16'd0, 16'hFFFF, 20'd0);
    push_ticks(8'b0000_0001, 5);
    // huge period: position saturates after the first beat, exponent saturates
    program_track(32'hFFFF_FFFF, 24'd2, 24'hFF_FFFF, 16'hFFFF, 16'h4000, 20'hF_FFFF);
    push_ticks(8'b0000_0001, 6);
    // length lowered mid-track, late first beat, zero-length track
    write_reg(REG_FIRST_BEAT, 32'd1);
    write_reg(REG_TRACK_LENGTH, 32'd2);
    push_ticks(8'b0000_0010, 3);
    write_reg(REG_TRACK_LENGTH, 32'd0);
    push_ticks(8'b0000_0010, 2);
    // one-sample period, one-sample click, decay step of 10.0
    program_track(32'd256, 24'd0, 24'hFF_FFFF, 16'd1, 16'd0, 20'd655360);
    push_ticks(8'b0000_0001, 3);

    // random tracks, mostly short so that beats and track ends come often
    rand_ticks = 0;
    while (rand_ticks < RANDOM_TICKS) begin
      set_idle((rand_ticks * 3) / RANDOM_TICKS);
      if ($urandom_range(7) == 0) begin
        per   = $urandom();
        first = ($urandom_range(1) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 8));
        len   = 24'($urandom_range(1, 24'hFF_FFFF));
        clen  = 16'($urandom());
        pstep = 16'($urandom());
        dstep = 20'($urandom());
        n     = $urandom_range(15, 40);
      end else begin
        per   = ($urandom_range(9) == 0) ? 32'($urandom_range(0, 255))
                                         : 32'($urandom_range(256, 40 * 256));
        first = 24'($urandom_range(0, 20));
        len   = 24'($urandom_range(8, 60));
        clen  = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
        pstep = 16'($urandom());
        dstep = 20'($urandom_range(0, 1 << 17));
        n     = int'(len) + $urandom_range(0, 15);
      end
      program_track(per, first, len, clen, pstep, dstep);
      append_tick($urandom_range(99) < 85);
      for (int i = 1; i < n; i++) begin
        append_tick($urandom_range(99) < 2);
      end
      rand_ticks += n;
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> metronome_click_track_generator.f
hw/rtl/mctg_pkg.sv
hw/rtl/mctg_front.sv
hw/rtl/mctg_queue.sv
hw/rtl/mctg_back.sv
hw/rtl/metronome_click_track_generator.sv
tb/testbench.sv
